// ===== rtl/core/segx_pkg.sv =====
package segx_pkg;

	localparam int CoordBits = 12;
	localparam int FracBits  = 8;
	// Line coefficients a and b, signed.
	localparam int AB = CoordBits + 1;
	// Products of a coefficient and a coordinate.
	localparam int PB = 2 * CoordBits + 2;
	// Constant term c and the determinant, signed.
	localparam int CB = 2 * CoordBits + 3;
	// Products of a coefficient and a constant term.
	localparam int MB = AB + CB;
	// Cramer numerators, signed.
	localparam int NB = MB + 1;
	// Magnitude of the determinant.
	localparam int DU = 2 * CoordBits + 1;
	// Magnitude of a numerator whose point lies inside both boxes.
	localparam int NU = CoordBits + DU;
	// Product of a box bound and the determinant magnitude.
	localparam int BB = CoordBits + DU;
	// Fixed-point result width and divider remainder width.
	localparam int XW = CoordBits + FracBits;
	localparam int RW = NU + FracBits;

	localparam logic [1:0] ST_INSIDE   = 2'd0;
	localparam logic [1:0] ST_PARALLEL = 2'd1;
	localparam logic [1:0] ST_OUT      = 2'd2;

	typedef struct packed {
		logic [CoordBits-1:0] seg_a_start_x;
		logic [CoordBits-1:0] seg_a_start_y;
		logic [CoordBits-1:0] seg_a_end_x;
		logic [CoordBits-1:0] seg_a_end_y;
		logic [CoordBits-1:0] seg_b_start_x;
		logic [CoordBits-1:0] seg_b_start_y;
		logic [CoordBits-1:0] seg_b_end_x;
		logic [CoordBits-1:0] seg_b_end_y;
	} req_t;

	typedef struct packed {
		logic [1:0]    hit_status;
		logic [XW-1:0] cross_x;
		logic [XW-1:0] cross_y;
	} rsp_t;

	// Handoff from the geometry stages to the divider.
	typedef struct packed {
		logic [1:0]    status;
		logic [NU-1:0] num_x;
		logic [NU-1:0] num_y;
		logic [DU-1:0] det;
	} geo_t;

endpackage

// ===== rtl/core/segment_intersection_unit.sv =====
// Pipeline: 8 geometry stages followed by one divider stage per quotient bit (20).
// Throughput: one request per cycle; the whole pipeline advances together and
// holds only while a finished result waits on rsp_ready.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
module segment_intersection_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  segx_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output segx_pkg::rsp_t  rsp
);

	logic           adv;
	logic           geo_valid;
	segx_pkg::geo_t geo;

	// The pipeline moves whenever its last stage is empty or being drained.
	// A stalled result freezes every stage, so nothing is lost or repeated,
	// and bubbles behind it are not squeezed out while it waits.
	assign adv       = rsp_ready || !rsp_valid;
	assign req_ready = adv;

	// Line coefficients, determinant, Cramer numerators and the exact box test.
	// A request with a zero determinant leaves here marked parallel.
	segx_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (req_valid),
		.in_data   (req),
		.out_valid (geo_valid),
		.out_data  (geo)
	);

	// Fixed-point quotients of both numerators by the determinant magnitude.
	// Its last stage is the output register; the point reads as zero unless
	// the crossing lies inside both segments.
	segx_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (geo_valid),
		.in_data   (geo),
		.out_valid (rsp_valid),
		.out_data  (rsp)
	);

endmodule

// ===== rtl/core/segx_geom.sv =====
module segx_geom (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  segx_pkg::req_t  in_data,
	output logic            out_valid,
	output segx_pkg::geo_t  out_data
);

	localparam int C  = segx_pkg::CoordBits;
	localparam int AB = segx_pkg::AB;
	localparam int PB = segx_pkg::PB;
	localparam int CB = segx_pkg::CB;
	localparam int MB = segx_pkg::MB;
	localparam int NB = segx_pkg::NB;
	localparam int DU = segx_pkg::DU;
	localparam int BB = segx_pkg::BB;
	localparam int NU = segx_pkg::NU;

	logic [7:0] v_q;

	// Stage 1: coordinates and line coefficients.
	logic [C-1:0]         ax0_s1, ay0_s1, ax1_s1, ay1_s1;
	logic [C-1:0]         bx0_s1, by0_s1, bx1_s1, by1_s1;
	logic signed [AB-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
	// Stage 2: first products and bounding boxes.
	logic signed [AB-1:0] a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [PB-1:0] p1x_s2, p1y_s2, p2x_s2, p2y_s2, da_s2, db_s2;
	logic [C-1:0]         lxa_s2, hxa_s2, lya_s2, hya_s2;
	logic [C-1:0]         lxb_s2, hxb_s2, lyb_s2, hyb_s2;
	// Stage 3: constant terms and determinant.
	logic signed [AB-1:0] a1_s3, b1_s3, a2_s3, b2_s3;
	logic signed [CB-1:0] c1_s3, c2_s3, det_s3;
	logic [C-1:0]         lxa_s3, hxa_s3, lya_s3, hya_s3;
	logic [C-1:0]         lxb_s3, hxb_s3, lyb_s3, hyb_s3;
	// Stage 4: numerator products.
	logic signed [MB-1:0] m1_s4, m2_s4, m3_s4, m4_s4;
	logic signed [CB-1:0] det_s4;
	logic [C-1:0]         lxa_s4, hxa_s4, lya_s4, hya_s4;
	logic [C-1:0]         lxb_s4, hxb_s4, lyb_s4, hyb_s4;
	// Stage 5: numerators.
	logic signed [NB-1:0] nx_s5, ny_s5;
	logic signed [CB-1:0] det_s5;
	logic                 par_s5;
	logic [C-1:0]         lxa_s5, hxa_s5, lya_s5, hya_s5;
	logic [C-1:0]         lxb_s5, hxb_s5, lyb_s5, hyb_s5;
	// Stage 6: sign made positive on the determinant.
	logic signed [NB-1:0] nx_s6, ny_s6;
	logic [DU-1:0]        det_s6;
	logic                 par_s6;
	logic [C-1:0]         lxa_s6, hxa_s6, lya_s6, hya_s6;
	logic [C-1:0]         lxb_s6, hxb_s6, lyb_s6, hyb_s6;
	// Stage 7: box bounds scaled by the determinant.
	logic signed [NB-1:0] nx_s7, ny_s7;
	logic [DU-1:0]        det_s7;
	logic                 par_s7;
	logic [BB-1:0]        lxa_s7, hxa_s7, lya_s7, hya_s7;
	logic [BB-1:0]        lxb_s7, hxb_s7, lyb_s7, hyb_s7;
	// Stage 8: box test.
	segx_pkg::geo_t       geo_s8;

	logic in_box;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[6:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax0_s1 <= in_data.seg_a_start_x;
			ay0_s1 <= in_data.seg_a_start_y;
			ax1_s1 <= in_data.seg_a_end_x;
			ay1_s1 <= in_data.seg_a_end_y;
			bx0_s1 <= in_data.seg_b_start_x;
			by0_s1 <= in_data.seg_b_start_y;
			bx1_s1 <= in_data.seg_b_end_x;
			by1_s1 <= in_data.seg_b_end_y;
			a1_s1  <= $signed({1'b0, in_data.seg_a_end_y}) - $signed({1'b0, in_data.seg_a_start_y});
			b1_s1  <= $signed({1'b0, in_data.seg_a_start_x}) - $signed({1'b0, in_data.seg_a_end_x});
			a2_s1  <= $signed({1'b0, in_data.seg_b_end_y}) - $signed({1'b0, in_data.seg_b_start_y});
			b2_s1  <= $signed({1'b0, in_data.seg_b_start_x}) - $signed({1'b0, in_data.seg_b_end_x});

			a1_s2  <= a1_s1;
			b1_s2  <= b1_s1;
			a2_s2  <= a2_s1;
			b2_s2  <= b2_s1;
			p1x_s2 <= PB'(a1_s1) * PB'($signed({1'b0, ax0_s1}));
			p1y_s2 <= PB'(b1_s1) * PB'($signed({1'b0, ay0_s1}));
			p2x_s2 <= PB'(a2_s1) * PB'($signed({1'b0, bx0_s1}));
			p2y_s2 <= PB'(b2_s1) * PB'($signed({1'b0, by0_s1}));
			da_s2  <= PB'(a1_s1) * PB'(b2_s1);
			db_s2  <= PB'(a2_s1) * PB'(b1_s1);
			lxa_s2 <= (ax0_s1 < ax1_s1) ? ax0_s1 : ax1_s1;
			hxa_s2 <= (ax0_s1 < ax1_s1) ? ax1_s1 : ax0_s1;
			lya_s2 <= (ay0_s1 < ay1_s1) ? ay0_s1 : ay1_s1;
			hya_s2 <= (ay0_s1 < ay1_s1) ? ay1_s1 : ay0_s1;
			lxb_s2 <= (bx0_s1 < bx1_s1) ? bx0_s1 : bx1_s1;
			hxb_s2 <= (bx0_s1 < bx1_s1) ? bx1_s1 : bx0_s1;
			lyb_s2 <= (by0_s1 < by1_s1) ? by0_s1 : by1_s1;
			hyb_s2 <= (by0_s1 < by1_s1) ? by1_s1 : by0_s1;

			a1_s3  <= a1_s2;
			b1_s3  <= b1_s2;
			a2_s3  <= a2_s2;
			b2_s3  <= b2_s2;
			c1_s3  <= CB'(p1x_s2) + CB'(p1y_s2);
			c2_s3  <= CB'(p2x_s2) + CB'(p2y_s2);
			det_s3 <= CB'(da_s2) - CB'(db_s2);
			lxa_s3 <= lxa_s2;
			hxa_s3 <= hxa_s2;
			lya_s3 <= lya_s2;
			hya_s3 <= hya_s2;
			lxb_s3 <= lxb_s2;
			hxb_s3 <= hxb_s2;
			lyb_s3 <= lyb_s2;
			hyb_s3 <= hyb_s2;

			m1_s4  <= MB'(b2_s3) * MB'(c1_s3);
			m2_s4  <= MB'(b1_s3) * MB'(c2_s3);
			m3_s4  <= MB'(a1_s3) * MB'(c2_s3);
			m4_s4  <= MB'(a2_s3) * MB'(c1_s3);
			det_s4 <= det_s3;
			lxa_s4 <= lxa_s3;
			hxa_s4 <= hxa_s3;
			lya_s4 <= lya_s3;
			hya_s4 <= hya_s3;
			lxb_s4 <= lxb_s3;
			hxb_s4 <= hxb_s3;
			lyb_s4 <= lyb_s3;
			hyb_s4 <= hyb_s3;

			nx_s5  <= NB'(m1_s4) - NB'(m2_s4);
			ny_s5  <= NB'(m3_s4) - NB'(m4_s4);
			det_s5 <= det_s4;
			par_s5 <= (det_s4 == '0);
			lxa_s5 <= lxa_s4;
			hxa_s5 <= hxa_s4;
			lya_s5 <= lya_s4;
			hya_s5 <= hya_s4;
			lxb_s5 <= lxb_s4;
			hxb_s5 <= hxb_s4;
			lyb_s5 <= lyb_s4;
			hyb_s5 <= hyb_s4;

			if (det_s5[CB-1]) begin
				nx_s6  <= -nx_s5;
				ny_s6  <= -ny_s5;
				det_s6 <= DU'(-det_s5);
			end else begin
				nx_s6  <= nx_s5;
				ny_s6  <= ny_s5;
				det_s6 <= DU'(det_s5);
			end
			par_s6 <= par_s5;
			lxa_s6 <= lxa_s5;
			hxa_s6 <= hxa_s5;
			lya_s6 <= lya_s5;
			hya_s6 <= hya_s5;
			lxb_s6 <= lxb_s5;
			hxb_s6 <= hxb_s5;
			lyb_s6 <= lyb_s5;
			hyb_s6 <= hyb_s5;

			nx_s7  <= nx_s6;
			ny_s7  <= ny_s6;
			det_s7 <= det_s6;
			par_s7 <= par_s6;
			lxa_s7 <= BB'(lxa_s6) * BB'(det_s6);
			hxa_s7 <= BB'(hxa_s6) * BB'(det_s6);
			lya_s7 <= BB'(lya_s6) * BB'(det_s6);
			hya_s7 <= BB'(hya_s6) * BB'(det_s6);
			lxb_s7 <= BB'(lxb_s6) * BB'(det_s6);
			hxb_s7 <= BB'(hxb_s6) * BB'(det_s6);
			lyb_s7 <= BB'(lyb_s6) * BB'(det_s6);
			hyb_s7 <= BB'(hyb_s6) * BB'(det_s6);

			if (par_s7) begin
				geo_s8.status <= segx_pkg::ST_PARALLEL;
			end else if (in_box) begin
				geo_s8.status <= segx_pkg::ST_INSIDE;
			end else begin
				geo_s8.status <= segx_pkg::ST_OUT;
			end
			geo_s8.num_x <= nx_s7[NU-1:0];
			geo_s8.num_y <= ny_s7[NU-1:0];
			geo_s8.det   <= det_s7;
		end
	end

	// Exact inclusive test of the point against both segments' boxes.
	assign in_box = ($signed(NB'(lxa_s7)) <= nx_s7) && (nx_s7 <= $signed(NB'(hxa_s7)))
		&& ($signed(NB'(lya_s7)) <= ny_s7) && (ny_s7 <= $signed(NB'(hya_s7)))
		&& ($signed(NB'(lxb_s7)) <= nx_s7) && (nx_s7 <= $signed(NB'(hxb_s7)))
		&& ($signed(NB'(lyb_s7)) <= ny_s7) && (ny_s7 <= $signed(NB'(hyb_s7)));

	assign out_valid = v_q[7];
	assign out_data  = geo_s8;

endmodule

// ===== rtl/core/segx_div.sv =====
module segx_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  segx_pkg::geo_t  in_data,
	output logic            out_valid,
	output segx_pkg::rsp_t  out_data
);

	localparam int XW = segx_pkg::XW;
	localparam int RW = segx_pkg::RW;
	localparam int DU = segx_pkg::DU;
	localparam int FB = segx_pkg::FracBits;

	logic [XW-1:0] v_q;
	logic [RW-1:0] rx_s  [XW];
	logic [RW-1:0] ry_s  [XW];
	logic [XW-1:0] qx_s  [XW];
	logic [XW-1:0] qy_s  [XW];
	logic [DU-1:0] det_s [XW];
	logic [1:0]    st_s  [XW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[XW-2:0], in_valid};
		end
	end

	// Restoring division, one quotient bit per stage, most significant first.
	for (genvar i = 0; i < XW; i++) begin : g_step
		logic [RW-1:0] rx_in, ry_in, dsh;
		logic [XW-1:0] qx_in, qy_in;
		logic [DU-1:0] det_in;
		logic [1:0]    st_in;
		logic          bx, by;

		if (i == 0) begin : g_first
			assign rx_in  = {in_data.num_x, {FB{1'b0}}};
			assign ry_in  = {in_data.num_y, {FB{1'b0}}};
			assign qx_in  = '0;
			assign qy_in  = '0;
			assign det_in = in_data.det;
			assign st_in  = in_data.status;
		end else begin : g_next
			assign rx_in  = rx_s[i-1];
			assign ry_in  = ry_s[i-1];
			assign qx_in  = qx_s[i-1];
			assign qy_in  = qy_s[i-1];
			assign det_in = det_s[i-1];
			assign st_in  = st_s[i-1];
		end

		assign dsh = RW'(det_in) << (XW - 1 - i);
		assign bx  = (rx_in >= dsh);
		assign by  = (ry_in >= dsh);

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[i]  <= bx ? rx_in - dsh : rx_in;
				ry_s[i]  <= by ? ry_in - dsh : ry_in;
				qx_s[i]  <= {qx_in[XW-2:0], bx};
				qy_s[i]  <= {qy_in[XW-2:0], by};
				det_s[i] <= det_in;
				st_s[i]  <= st_in;
			end
		end
	end

	assign out_valid           = v_q[XW-1];
	assign out_data.hit_status = st_s[XW-1];
	assign out_data.cross_x    = (st_s[XW-1] == segx_pkg::ST_INSIDE) ? qx_s[XW-1] : '0;
	assign out_data.cross_y    = (st_s[XW-1] == segx_pkg::ST_INSIDE) ? qy_s[XW-1] : '0;

endmodule
